// ===== hdl/adpcma_pkg.sv =====
`timescale 1ns / 1ps
package adpcma_pkg;

  localparam int ACC_W  = 14;  // saturated accumulator, two's complement
  localparam int SUM_W  = 15;  // accumulator plus delta before clamping
  localparam int STEP_W = 13;  // step size ROM word
  localparam int IDX_W  = 6;   // step index 0..48
  localparam int CH_W   = 3;
  localparam int CODE_W = 4;
  localparam int PROD_W = STEP_W + CODE_W;

  localparam logic signed [ACC_W-1:0] ACC_MAX = 14'sd6143;
  localparam logic signed [ACC_W-1:0] ACC_MIN = -14'sd6144;
  localparam logic signed [SUM_W-1:0] SUM_MAX = 15'sd6143;
  localparam logic signed [SUM_W-1:0] SUM_MIN = -15'sd6144;
  localparam logic [IDX_W-1:0]        IDX_MAX = 6'd48;

  typedef enum logic {
    REQ_DECODE = 1'b0,
    REQ_KEY_ON = 1'b1
  } req_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] acc;
    logic [IDX_W-1:0]        idx;
  } chan_state_t;

  // floor(48 * 1.1^i)
  function automatic logic [STEP_W-1:0] step_size(input logic [IDX_W-1:0] idx);
    logic [STEP_W-1:0] s;
    unique case (idx)
      6'd0:  s = 13'd48;    6'd1:  s = 13'd52;    6'd2:  s = 13'd58;
      6'd3:  s = 13'd63;    6'd4:  s = 13'd70;    6'd5:  s = 13'd77;
      6'd6:  s = 13'd85;    6'd7:  s = 13'd93;    6'd8:  s = 13'd102;
      6'd9:  s = 13'd113;   6'd10: s = 13'd124;   6'd11: s = 13'd136;
      6'd12: s = 13'd150;   6'd13: s = 13'd165;   6'd14: s = 13'd182;
      6'd15: s = 13'd200;   6'd16: s = 13'd220;   6'd17: s = 13'd242;
      6'd18: s = 13'd266;   6'd19: s = 13'd293;   6'd20: s = 13'd322;
      6'd21: s = 13'd355;   6'd22: s = 13'd390;   6'd23: s = 13'd429;
      6'd24: s = 13'd472;   6'd25: s = 13'd520;   6'd26: s = 13'd572;
      6'd27: s = 13'd629;   6'd28: s = 13'd692;   6'd29: s = 13'd761;
      6'd30: s = 13'd837;   6'd31: s = 13'd921;   6'd32: s = 13'd1013;
      6'd33: s = 13'd1114;  6'd34: s = 13'd1226;  6'd35: s = 13'd1348;
      6'd36: s = 13'd1483;  6'd37: s = 13'd1632;  6'd38: s = 13'd1795;
      6'd39: s = 13'd1974;  6'd40: s = 13'd2172;  6'd41: s = 13'd2389;
      6'd42: s = 13'd2628;  6'd43: s = 13'd2891;  6'd44: s = 13'd3180;
      6'd45: s = 13'd3498;  6'd46: s = 13'd3848;  6'd47: s = 13'd4233;
      default: s = 13'd4656;  // top entry; the index never exceeds it
    endcase
    return s;
  endfunction

  function automatic logic signed [4:0] index_adjust(input logic [2:0] mag);
    logic signed [4:0] a;
    unique case (mag)
      3'd4:    a = 5'sd2;
      3'd5:    a = 5'sd5;
      3'd6:    a = 5'sd7;
      3'd7:    a = 5'sd9;
      default: a = -5'sd1;
    endcase
    return a;
  endfunction

endpackage

// ===== hdl/adpcma_step.sv =====
`timescale 1ns / 1ps
module adpcma_step
  import adpcma_pkg::*;
(
  input  chan_state_t       cur,
  input  logic [CODE_W-1:0] code,
  output chan_state_t       nxt
);

  logic [STEP_W-1:0]       step;
  logic [CODE_W-1:0]       odd;
  logic [PROD_W-1:0]       prod;
  logic signed [SUM_W-1:0] mag_s;
  logic signed [SUM_W-1:0] delta;
  logic signed [SUM_W-1:0] sum;
  logic signed [7:0]       ni;

  assign step  = step_size(cur.idx);
  assign odd   = {code[2:0], 1'b1};
  assign prod  = {{CODE_W{1'b0}}, step} * {{STEP_W{1'b0}}, odd};
  // divide by eight: all terms are positive, so truncation is a plain shift
  assign mag_s = $signed({1'b0, prod[PROD_W-1:3]});
  assign delta = code[3] ? -mag_s : mag_s;
  assign sum   = $signed({cur.acc[ACC_W-1], cur.acc}) + delta;
  assign ni    = $signed({2'b00, cur.idx}) + 8'(index_adjust(code[2:0]));

  always_comb begin
    priority if (sum > SUM_MAX) begin
      nxt.acc = ACC_MAX;
    end else if (sum < SUM_MIN) begin
      nxt.acc = ACC_MIN;
    end else begin
      nxt.acc = sum[ACC_W-1:0];
    end
    priority if (ni < 8'sd0) begin
      nxt.idx = '0;
    end else if (ni > $signed({2'b00, IDX_MAX})) begin
      nxt.idx = IDX_MAX;
    end else begin
      nxt.idx = ni[IDX_W-1:0];
    end
  end

endmodule

// ===== hdl/adpcm_a_channel_decoder.sv =====
`timescale 1ns / 1ps
// Multi-channel 4-bit ADPCM-A decoder.
//
// Input channel (in_valid / in_ready): one transaction is either a key-on for
// a channel (in_req_type = 1), which clears that channel's accumulator and
// step index and yields nothing, or one code nibble (in_req_type = 0), which
// yields the channel's new sample on the output channel. Transactions aimed
// at a channel number of NUM_CHANNELS or above are dropped silently.
//
// Output channel (out_valid / out_ready): out_channel and out_sample, the
// saturated accumulator in -6144..6143.
//
// A nibble accepted into the input register is decoded there and its sample
// goes into the result register, which drives out_valid, once that register
// is free. Throughput: one transaction every cycle unless the receiver stalls
// the result register, set by the per-channel read-modify-write of the state,
// which passes the step ROM, one 13 x 4 multiply, the add and the clamps
// combinationally. Consecutive nibbles for the same channel need no bypass:
// the state is written at the edge the earlier one leaves the input register.
//
// Reset clears all channel state and empties both registers. When the
// receiver stalls, the result register holds and the input register holds
// behind it; in_ready drops only once both are full.
module adpcm_a_channel_decoder
  import adpcma_pkg::*;
#(
  parameter int NUM_CHANNELS = 6
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_req_type,
  input  logic [CH_W-1:0]         in_channel,
  input  logic [CODE_W-1:0]       in_nibble,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [CH_W-1:0]         out_channel,
  output logic signed [ACC_W-1:0] out_sample
);

  localparam int SEL_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  // input register
  logic              s1_v_r;
  logic              s1_req_r;
  logic [CH_W-1:0]   s1_ch_r;
  logic [CODE_W-1:0] s1_code_r;

  // result register
  logic                    out_valid_r;
  logic [CH_W-1:0]         out_ch_r;
  logic signed [ACC_W-1:0] out_sample_r;

  chan_state_t state_r [NUM_CHANNELS];

  logic [4:0]       s1_ch_ext;
  logic [SEL_W-1:0] s1_sel;
  logic             ch_ok;
  logic             s1_emit;
  logic             out_free;
  logic             s1_go;
  chan_state_t      cur;
  chan_state_t      nxt;

  assign s1_ch_ext = {2'b00, s1_ch_r};
  assign s1_sel    = s1_ch_ext[SEL_W-1:0];
  assign ch_ok     = s1_ch_ext < 5'(NUM_CHANNELS);
  assign cur       = state_r[s1_sel];

  adpcma_step u_step (
    .cur  (cur),
    .code (s1_code_r),
    .nxt  (nxt)
  );

  // only an in-range decode produces a result; everything else retires freely
  assign s1_emit  = s1_v_r && ch_ok && (req_t'(s1_req_r) == REQ_DECODE);
  assign out_free = !out_valid_r || out_ready;
  assign s1_go    = s1_v_r && (!s1_emit || out_free);
  assign in_ready = !s1_v_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_ready) begin
      s1_v_r <= in_valid;
    end
  end

  // payload: capture on every accepted transaction
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_req_r  <= in_req_type;
      s1_ch_r   <= in_channel;
      s1_code_r <= in_nibble;
    end
  end

  // channel state: commit as the transaction leaves the input register
  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      if (!rst_n) begin
        state_r[i] <= '0;
      end else if (s1_go && ch_ok && (s1_sel == SEL_W'(i))) begin
        if (req_t'(s1_req_r) == REQ_KEY_ON) begin
          state_r[i] <= '0;
        end else begin
          state_r[i] <= nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && s1_emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_emit) begin
      out_ch_r     <= s1_ch_r;
      out_sample_r <= nxt.acc;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_channel = out_ch_r;
  assign out_sample  = out_sample_r;

  // a decode leaving the input register must land in the result register
  a_emit_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && s1_emit) |=> out_valid_r)
    else $error("decoded sample lost");

  // a key-on leaves the addressed channel cleared
  a_key_on_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && ch_ok && s1_req_r) |=>
      (state_r[$past(s1_sel)].acc == '0 && state_r[$past(s1_sel)].idx == '0))
    else $error("key-on did not clear channel state");

  // committed step index stays inside the ROM
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    s1_emit |-> (nxt.idx <= IDX_MAX))
    else $error("step index out of range");

  // presented samples stay inside the saturation limits
  a_sample_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_sample_r <= ACC_MAX && out_sample_r >= ACC_MIN))
    else $error("sample outside saturation limits");

  // nothing is dropped while the result register is blocked
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready && s1_emit) |-> !s1_go)
    else $error("result register overwritten while stalled");

endmodule
